// ----- design/efgw_pkg.sv -----
`timescale 1ns / 1ps
package efgw_pkg;
    localparam int WAITER_SLOTS = 8;
    localparam int FLAG_BITS    = 24;
    localparam int ID_BITS      = 8;
    localparam int SLOT_W       = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int ENTRY_W      = FLAG_BITS + ID_BITS + 2;

    localparam logic [1:0] MODE_WAIT    = 2'd0;
    localparam logic [1:0] MODE_SET     = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;
    localparam logic [1:0] MODE_TIMEOUT = 2'd3;

    localparam logic [2:0] KIND_NOW       = 3'd0;
    localparam logic [2:0] KIND_BLOCKED   = 3'd1;
    localparam logic [2:0] KIND_WOKEN     = 3'd2;
    localparam logic [2:0] KIND_TIMEDOUT  = 3'd3;
    localparam logic [2:0] KIND_SETDONE   = 3'd4;
    localparam logic [2:0] KIND_CLEARDONE = 3'd5;
    localparam logic [2:0] KIND_REJECT    = 3'd6;
endpackage

// ----- design/efgw_ram.sv -----
`timescale 1ns / 1ps
module efgw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- design/event_flag_group_waiters.sv -----
`timescale 1ns / 1ps
// Event flag group with a table of blocked waiters.
// Input channel: i_in_valid / o_in_stall with mode, bits, waiter_id,
// clear_on_exit, wait_all and may_block. A transaction is taken only while
// the block is idle; o_in_stall is high while an item is being worked on.
// Output channel: o_out_valid / i_out_stall with kind, who, flags_value and
// last; o_last marks the final result of an item.
// Flow: a clear item, or a wait that returns or is rejected at once,
// gives its result from the decide state. Wait items that block, set
// items and timeout items sweep the waiter table held in a one-port-read
// RAM, slot by slot (address, then registered data).
// A timeout stops at the slot that holds its waiter.
// Reset clears the flag word, every slot valid bit and the output valid bit;
// the entries themselves need no clearing as they are used only when valid.
// When the receiver stalls, the pending result holds and the sweep waits on
// the slot that has the next result to give.
module event_flag_group_waiters
    import efgw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic [FLAG_BITS-1:0] i_bits,
    input  logic [ID_BITS-1:0]   i_waiter_id,
    input  logic                 i_clear_on_exit,
    input  logic                 i_wait_all,
    input  logic                 i_may_block,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_kind,
    output logic [ID_BITS-1:0]   o_who,
    output logic [FLAG_BITS-1:0] o_flags_value,
    output logic                 o_last
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD,
        S_CHK,
        S_DONE
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WAITER_SLOTS - 1);

    t_state                  r_state;
    logic [1:0]              r_mode;
    logic [FLAG_BITS-1:0]    r_bits;
    logic [ID_BITS-1:0]      r_id;
    logic                    r_clr;
    logic                    r_all;
    logic                    r_may_block;
    logic [FLAG_BITS-1:0]    r_flags;
    logic [FLAG_BITS-1:0]    r_gather;
    logic [WAITER_SLOTS-1:0] r_slot_valid;
    logic [SLOT_W-1:0]       r_idx;
    logic                    r_found;
    logic                    r_out_valid;

    logic                    out_free;
    logic                    ram_we;
    logic                    ram_re;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [FLAG_BITS-1:0]    e_mask;
    logic [ID_BITS-1:0]      e_id;
    logic                    e_clr;
    logic                    e_all;
    logic                    have_free;
    logic [SLOT_W-1:0]       free_slot;
    logic                    cur_valid;
    logic                    e_cond;
    logic                    in_cond;

    function automatic logic cond_holds(input logic [FLAG_BITS-1:0] flags,
                                        input logic [FLAG_BITS-1:0] mask,
                                        input logic all);
        if (all) begin
            return (flags & mask) == mask;
        end
        return (flags & mask) != '0;
    endfunction

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign ram_re     = (r_state == S_RD);
    assign ram_we     = (r_state == S_DONE) && out_free && (r_mode == MODE_WAIT)
                        && have_free && !r_found;

    // Entry layout: mask, id, clear flag, all flag
    assign e_mask = ram_rdata[ENTRY_W-1 -: FLAG_BITS];
    assign e_id   = ram_rdata[2 +: ID_BITS];
    assign e_clr  = ram_rdata[1];
    assign e_all  = ram_rdata[0];

    assign cur_valid = r_slot_valid[r_idx];
    assign e_cond    = cond_holds(r_flags, e_mask, e_all);
    assign in_cond   = cond_holds(r_flags, r_bits, r_all);

    // Lowest free slot
    always_comb begin
        have_free = 1'b0;
        free_slot = '0;
        for (int i = WAITER_SLOTS - 1; i >= 0; i--) begin
            if (!r_slot_valid[i]) begin
                have_free = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    efgw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WAITER_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (free_slot),
        .i_wdata ({r_bits, r_id, r_clr, r_all}),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_flags      <= '0;
            r_slot_valid <= '0;
        end else begin
            // drop the result once taken; an emission below overrides
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode      <= i_mode;
                        r_bits      <= i_bits;
                        r_id        <= i_waiter_id;
                        r_clr       <= i_clear_on_exit;
                        r_all       <= i_wait_all;
                        r_may_block <= i_may_block;
                        r_idx       <= '0;
                        r_found     <= 1'b0;
                        r_gather    <= '0;
                        r_state     <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    case (r_mode)
                        MODE_WAIT: begin
                            if (r_bits == '0 || in_cond || !r_may_block) begin
                                if (out_free) begin
                                    r_out_valid   <= 1'b1;
                                    o_kind        <= (r_bits == '0) ? KIND_REJECT
                                                                    : KIND_NOW;
                                    o_who         <= r_id;
                                    o_flags_value <= r_flags;
                                    o_last        <= 1'b1;
                                    if (r_bits != '0 && in_cond && r_clr) begin
                                        r_flags <= r_flags & ~r_bits;
                                    end
                                    r_state <= S_IDLE;
                                end
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                        MODE_SET: begin
                            r_flags <= r_flags | r_bits;
                            r_state <= S_RD;
                        end
                        MODE_CLEAR: begin
                            if (out_free) begin
                                r_out_valid   <= 1'b1;
                                o_kind        <= KIND_CLEARDONE;
                                o_who         <= '0;
                                o_flags_value <= r_flags;
                                o_last        <= 1'b1;
                                r_flags       <= r_flags & ~r_bits;
                                r_state       <= S_IDLE;
                            end
                        end
                        default: begin
                            r_state <= S_RD;
                        end
                    endcase
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // hold here while a result for this slot cannot be placed
                    if (r_mode == MODE_SET && cur_valid && e_cond) begin
                        if (out_free) begin
                            r_out_valid         <= 1'b1;
                            o_kind              <= KIND_WOKEN;
                            o_who               <= e_id;
                            o_flags_value       <= r_flags;
                            o_last              <= 1'b0;
                            r_slot_valid[r_idx] <= 1'b0;
                            if (e_clr) begin
                                r_gather <= r_gather | e_mask;
                            end
                            r_idx   <= r_idx + 1'b1;
                            r_state <= (r_idx == LAST_SLOT) ? S_DONE : S_RD;
                        end
                    end else if (r_mode == MODE_TIMEOUT && cur_valid && e_id == r_id) begin
                        if (out_free) begin
                            r_out_valid         <= 1'b1;
                            o_kind              <= KIND_TIMEDOUT;
                            o_who               <= r_id;
                            o_flags_value       <= r_flags;
                            o_last              <= 1'b1;
                            r_slot_valid[r_idx] <= 1'b0;
                            if (e_cond && e_clr) begin
                                r_flags <= r_flags & ~e_mask;
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (r_mode == MODE_WAIT && cur_valid && e_id == r_id) begin
                            r_found <= 1'b1;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= (r_idx == LAST_SLOT) ? S_DONE : S_RD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        o_last        <= 1'b1;
                        r_state       <= S_IDLE;
                        case (r_mode)
                            MODE_WAIT: begin
                                o_who         <= r_id;
                                o_flags_value <= r_flags;
                                if (have_free && !r_found) begin
                                    o_kind                  <= KIND_BLOCKED;
                                    r_slot_valid[free_slot] <= 1'b1;
                                end else begin
                                    o_kind <= KIND_REJECT;
                                end
                            end
                            MODE_SET: begin
                                o_kind        <= KIND_SETDONE;
                                o_who         <= '0;
                                o_flags_value <= r_flags & ~r_gather;
                                r_flags       <= r_flags & ~r_gather;
                            end
                            default: begin
                                o_kind        <= KIND_REJECT;
                                o_who         <= r_id;
                                o_flags_value <= r_flags;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
